>>> rtl/core/ble_pkg.sv
// Shared constants and types for the bounded list engine.
// Holds operation codes, status codes and the cell control word.
// No dependencies.
`default_nettype none

package ble_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int VAL_W     = 32;

    // Operation codes carried by the input func field.
    localparam logic [2:0] FUNC_APPEND   = 3'd0;
    localparam logic [2:0] FUNC_POP_HEAD = 3'd1;
    localparam logic [2:0] FUNC_POP_TAIL = 3'd2;
    localparam logic [2:0] FUNC_DELETE   = 3'd3;
    localparam logic [2:0] FUNC_INSERT   = 3'd4;
    localparam logic [2:0] FUNC_TOGGLE   = 3'd5;
    localparam logic [2:0] FUNC_EXCHANGE = 3'd6;
    localparam logic [2:0] FUNC_READ     = 3'd7;

    // Result status codes.
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_EMPTY     = 2'd1;
    localparam logic [1:0] STAT_FULL      = 2'd2;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd3;

    typedef logic [2:0] t_cell_op;

    // Operations that every cell of the row carries out in the same cycle.
    localparam t_cell_op CELL_HOLD   = 3'd0;
    localparam t_cell_op CELL_APPEND = 3'd1;
    localparam t_cell_op CELL_POP    = 3'd2;
    localparam t_cell_op CELL_DELETE = 3'd3;
    localparam t_cell_op CELL_INSERT = 3'd4;
    localparam t_cell_op CELL_EXCH   = 3'd5;
    localparam t_cell_op CELL_ROT_L  = 3'd6;
    localparam t_cell_op CELL_ROT_R  = 3'd7;

    typedef struct packed {
        t_cell_op op;
        logic     ld_hit;
    } t_cell_ctl;

endpackage : ble_pkg

`default_nettype wire

>>> rtl/core/ble_cell.sv
// One storage cell of the list row: a value, its compare flags and the
// neighbour logic for shifts, rotation and first-match search. Uses ble_pkg.
`default_nettype none

module ble_cell #(
    parameter int IDX = 0,
    parameter int CW  = 5
) (
    input  wire logic                            i_clk,
    input  wire ble_pkg::t_cell_ctl              i_ctl,
    input  wire logic [CW-1:0]                   i_count,
    input  wire logic signed [ble_pkg::VAL_W-1:0] i_cmp_a,
    input  wire logic signed [ble_pkg::VAL_W-1:0] i_cmp_b,
    input  wire logic signed [ble_pkg::VAL_W-1:0] i_op_a,
    input  wire logic signed [ble_pkg::VAL_W-1:0] i_op_b,
    input  wire logic signed [ble_pkg::VAL_W-1:0] i_left_val,
    input  wire logic signed [ble_pkg::VAL_W-1:0] i_right_val,
    input  wire logic                            i_seen,
    input  wire logic                            i_left_first,
    output logic signed [ble_pkg::VAL_W-1:0]      o_val,
    output logic                                 o_seen,
    output logic                                 o_first
);
    import ble_pkg::*;

    logic signed [VAL_W-1:0] r_val;
    logic signed [VAL_W-1:0] n_val;
    logic                    r_hit_a;
    logic                    r_hit_b;
    logic                    w_occupied;

    assign w_occupied = CW'(IDX) < i_count;

    // Compare flags are taken when the item is transferred in.
    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_hit) begin
            r_hit_a <= w_occupied && (r_val == i_cmp_a);
            r_hit_b <= w_occupied && (r_val == i_cmp_b);
        end
        r_val <= n_val;
    end

    assign o_seen  = i_seen | r_hit_a;
    assign o_first = r_hit_a & ~i_seen;
    assign o_val   = r_val;

    always_comb begin
        n_val = r_val;
        case (i_ctl.op)
            CELL_APPEND: begin
                if (i_count == CW'(IDX)) begin
                    n_val = i_op_a;
                end
            end
            CELL_POP: n_val = i_right_val;
            CELL_DELETE: begin
                if (i_seen | r_hit_a) begin
                    n_val = i_right_val;
                end
            end
            CELL_INSERT: begin
                if (i_left_first) begin
                    n_val = i_op_b;
                end else if (i_seen) begin
                    n_val = i_left_val;
                end
            end
            CELL_EXCH: begin
                if (r_hit_a) begin
                    n_val = i_op_b;
                end else if (r_hit_b) begin
                    n_val = i_op_a;
                end
            end
            CELL_ROT_L: n_val = i_right_val;
            CELL_ROT_R: n_val = i_left_val;
            default:    n_val = r_val;
        endcase
    end

endmodule : ble_cell

`default_nettype wire

>>> rtl/core/bounded_list_engine.sv
// Bounded ordered list engine: a row of ble_cell instances, the operation
// sequencer and the output register. Uses ble_pkg and ble_cell.
//
// Usage
//   Input channel (i_valid / o_ready) carries func, value_a and value_b.
//   Output channel (o_valid / i_ready) carries value, is_entry, status, last.
//   Every operation other than a read-out gives one status result with last
//   set. A read-out of a non-empty list gives one result per entry, head to
//   tail, or tail to head when the reverse flag is set, the final one marked.
// Timing
//   A list operation has the transfer cycle, in which every cell compares
//   its value with value_a and value_b, and then the apply state, in which the
//   row updates in parallel and the status is written to the output register.
//   A read-out rotates the whole row once whatever the fill, one cell per
//   cycle while the output register is free; the row is back in order at its end.
// Reset and stalls
//   Reset empties the list and clears the reverse flag; cell contents are
//   not cleared. The output register holds one result; while the receiver
//   stalls, the sequencer waits with the next result and the row holds.
`default_nettype none

module bounded_list_engine #(
    parameter int DEPTH = ble_pkg::DEPTH_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire logic [2:0]                      i_func,
    input  wire logic signed [ble_pkg::VAL_W-1:0] i_value_a,
    input  wire logic signed [ble_pkg::VAL_W-1:0] i_value_b,
    output logic                                 o_valid,
    input  wire logic                            i_ready,
    output logic signed [ble_pkg::VAL_W-1:0]      o_value,
    output logic                                 o_is_entry,
    output logic [1:0]                           o_status,
    output logic                                 o_last
);
    import ble_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int KW = $clog2(DEPTH);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_APPLY = 2'd1;
    localparam logic [1:0] ST_READ  = 2'd2;

    logic [1:0]              r_state;
    logic [1:0]              n_state;
    logic [CW-1:0]           r_count;
    logic [CW-1:0]           n_count;
    logic                    r_reverse;
    logic                    n_reverse;
    logic [KW-1:0]           r_step;
    logic [KW-1:0]           n_step;
    logic [2:0]              r_func;
    logic signed [VAL_W-1:0] r_a;
    logic signed [VAL_W-1:0] r_b;

    logic                    r_o_valid;
    logic signed [VAL_W-1:0] r_o_value;
    logic                    r_o_is_entry;
    logic [1:0]              r_o_status;
    logic                    r_o_last;

    logic                    w_in_xfer;
    logic                    w_out_free;
    logic                    w_emit;
    logic signed [VAL_W-1:0] w_emit_value;
    logic                    w_emit_entry;
    logic [1:0]              w_emit_status;
    logic                    w_emit_last;
    logic                    w_empty;
    logic                    w_full;
    logic                    w_found;
    logic                    w_rd_hit;
    t_cell_ctl               w_ctl;

    logic signed [VAL_W-1:0] w_val   [DEPTH];
    logic                    w_seen  [DEPTH];
    logic                    w_first [DEPTH];

    assign o_ready    = (r_state == ST_IDLE);
    assign w_in_xfer  = i_valid & o_ready;
    assign w_out_free = ~r_o_valid | i_ready;
    assign w_empty    = (r_count == '0);
    assign w_full     = (r_count == CW'(DEPTH));
    assign w_found    = w_seen[DEPTH-1];

    // The row of cells; the ends wrap round so that a read-out can rotate it.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        ble_cell #(
            .IDX (g),
            .CW  (CW)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_count      (r_count),
            .i_cmp_a      (i_value_a),
            .i_cmp_b      (i_value_b),
            .i_op_a       (r_a),
            .i_op_b       (r_b),
            .i_left_val   (w_val[(g + DEPTH - 1) % DEPTH]),
            .i_right_val  (w_val[(g + 1) % DEPTH]),
            .i_seen       ((g == 0) ? 1'b0 : w_seen[(g + DEPTH - 1) % DEPTH]),
            .i_left_first ((g == 0) ? 1'b0 : w_first[(g + DEPTH - 1) % DEPTH]),
            .o_val        (w_val[g]),
            .o_seen       (w_seen[g]),
            .o_first      (w_first[g])
        );
    end

    // During a read-out, forward order takes cell 0 while the step is below
    // the count; reverse order takes the last cell once step + count reaches
    // the depth, which yields the tail first.
    always_comb begin
        if (r_reverse) begin
            w_rd_hit = ((CW + 1)'(r_step) + (CW + 1)'(r_count)) >= (CW + 1)'(DEPTH);
        end else begin
            w_rd_hit = (CW + 1)'(r_step) < (CW + 1)'(r_count);
        end
    end

    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_reverse     = r_reverse;
        n_step        = r_step;
        w_ctl.op      = CELL_HOLD;
        w_ctl.ld_hit  = w_in_xfer;
        w_emit        = 1'b0;
        w_emit_value  = '0;
        w_emit_entry  = 1'b0;
        w_emit_status = STAT_OK;
        w_emit_last   = 1'b1;

        unique case (r_state)
            ST_IDLE: begin
                if (w_in_xfer) begin
                    n_state = ST_APPLY;
                end
            end
            ST_APPLY: begin
                if (w_out_free) begin
                    w_emit  = 1'b1;
                    n_state = ST_IDLE;
                    case (r_func)
                        FUNC_APPEND: begin
                            if (w_full) begin
                                w_emit_status = STAT_FULL;
                            end else begin
                                w_ctl.op = CELL_APPEND;
                                n_count  = r_count + 1'b1;
                            end
                        end
                        FUNC_POP_HEAD: begin
                            if (w_empty) begin
                                w_emit_status = STAT_EMPTY;
                            end else begin
                                w_ctl.op = CELL_POP;
                                n_count  = r_count - 1'b1;
                            end
                        end
                        FUNC_POP_TAIL: begin
                            if (w_empty) begin
                                w_emit_status = STAT_EMPTY;
                            end else begin
                                n_count = r_count - 1'b1;
                            end
                        end
                        FUNC_DELETE: begin
                            if (w_empty) begin
                                w_emit_status = STAT_EMPTY;
                            end else if (!w_found) begin
                                w_emit_status = STAT_NOT_FOUND;
                            end else begin
                                w_ctl.op = CELL_DELETE;
                                n_count  = r_count - 1'b1;
                            end
                        end
                        FUNC_INSERT: begin
                            if (w_empty) begin
                                w_emit_status = STAT_EMPTY;
                            end else if (w_full) begin
                                w_emit_status = STAT_FULL;
                            end else if (!w_found) begin
                                w_emit_status = STAT_NOT_FOUND;
                            end else begin
                                w_ctl.op = CELL_INSERT;
                                n_count  = r_count + 1'b1;
                            end
                        end
                        FUNC_TOGGLE: begin
                            n_reverse = ~r_reverse;
                        end
                        FUNC_EXCHANGE: begin
                            if (w_empty) begin
                                w_emit_status = STAT_EMPTY;
                            end else begin
                                w_ctl.op = CELL_EXCH;
                            end
                        end
                        default: begin
                            // Read-out: an empty list reports at once,
                            // otherwise the row starts rotating.
                            if (w_empty) begin
                                w_emit_status = STAT_EMPTY;
                            end else begin
                                w_emit  = 1'b0;
                                n_state = ST_READ;
                                n_step  = '0;
                            end
                        end
                    endcase
                end
            end
            ST_READ: begin
                if (w_out_free) begin
                    w_ctl.op     = r_reverse ? CELL_ROT_R : CELL_ROT_L;
                    w_emit       = w_rd_hit;
                    w_emit_entry = 1'b1;
                    w_emit_value = r_reverse ? w_val[DEPTH-1] : w_val[0];
                    w_emit_last  = r_reverse ? (r_step == KW'(DEPTH - 1))
                                             : ((CW + 1)'(r_step) + 1'b1
                                                == (CW + 1)'(r_count));
                    if (r_step == KW'(DEPTH - 1)) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_step = r_step + 1'b1;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_reverse <= 1'b0;
            r_step    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_reverse <= n_reverse;
            r_step    <= n_step;
            if (w_emit) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_func <= i_func;
            r_a    <= i_value_a;
            r_b    <= i_value_b;
        end
        if (w_emit) begin
            r_o_value    <= w_emit_value;
            r_o_is_entry <= w_emit_entry;
            r_o_status   <= w_emit_status;
            r_o_last     <= w_emit_last;
        end
    end

    assign o_valid    = r_o_valid;
    assign o_value    = r_o_value;
    assign o_is_entry = r_o_is_entry;
    assign o_status   = r_o_status;
    assign o_last     = r_o_last;

endmodule : bounded_list_engine

`default_nettype wire
